// File: design/asde_pkg.sv
package asde_pkg;

  localparam int REG_ADDR_W = 4;

  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_SUSTAIN = 2'd1;
  localparam logic [1:0] REG_DECAY   = 2'd2;
  localparam logic [1:0] REG_LOOPED  = 2'd3;

  typedef struct packed {
    logic start;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: design/asde_div.sv
module asde_div import asde_pkg::*; #(
  parameter int NUM_W = 24,
  parameter int Q_W   = 17
) (
  input  logic             clk,
  input  logic             rst,
  input  div_ctrl_t        ctrl,
  input  logic [NUM_W-1:0] num,
  input  logic [NUM_W-1:0] den,
  output div_stat_t        stat,
  output logic [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(Q_W);

  logic [NUM_W:0]   rem;
  logic [NUM_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic             ge;
  logic [NUM_W:0]   rem_sub;

  always_comb begin
    ge      = rem >= {1'b0, divisor};
    rem_sub = ge ? rem - {1'b0, divisor} : rem;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(Q_W - 1);
        rem     <= {1'b0, num};
        divisor <= den;
      end else if (busy) begin
        quot <= {quot[Q_W-2:0], ge};
        rem  <= {rem_sub[NUM_W-1:0], 1'b0};
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// File: design/attack_sustain_decay_envelope.sv
// Attack, sustain and decay envelope, advanced one tick per input item.
// Input stream: s_tdata carries delta_time, s_tuser carries restart, which
// re-creates the envelope before the tick is applied. Output stream: one
// item per input item, m_tdata carries strength (FRAC_BITS fraction bits,
// one is 1 << FRAC_BITS), m_tuser carries alive.
// Phase times and the looped-sustain flag are written over the APB port at
// byte addresses 0, 4, 8 and 12; the user must do so only while no item is in
// flight, which the block itself does not enforce. An item is taken only
// when the block is idle. A tick that ramps (attack or decay) runs a
// restoring divider that yields one quotient bit a cycle; a tick with a
// constant level skips the divider. The next item is accepted in the cycle
// after the result enters the output register, so no new item is taken before
// the last one is through.
// When the receiver stalls, the result waits in the output register while
// the next item is worked on; that item then waits until the register frees.
// Reset clears the phase times, the looped flag, the phase age and done flags and
// the output valid, and starts the envelope in its endless state at full strength.
module attack_sustain_decay_envelope import asde_pkg::*; #(
  parameter int TIME_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [15:0]           s_tdata,   // delta_time
  input  logic                  s_tuser,   // restart
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [((FRAC_BITS + 8) / 8) * 8 - 1:0] m_tdata,   // strength, zero fill
  output logic                  m_tuser,   // alive
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int LVL_W = FRAC_BITS + 1;
  localparam int OUT_W = ((LVL_W + 7) / 8) * 8;
  localparam int AGE_W = TIME_BITS + 1;
  localparam int SUM_W = ((AGE_W > 16) ? AGE_W : 16) + 1;
  localparam logic [LVL_W-1:0] LEVEL_ONE = LVL_W'(1) << FRAC_BITS;
  localparam logic [SUM_W-1:0] AGE_MAX   = SUM_W'({AGE_W{1'b1}});

  typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} state_t;

  logic [TIME_BITS-1:0] attack_time;
  logic [TIME_BITS-1:0] sustain_time;
  logic [TIME_BITS-1:0] decay_time;
  logic                 looped_sustain;

  state_t               state;
  logic [AGE_W-1:0]     phase_age;
  logic                 attack_done;
  logic                 sustain_done;
  logic                 endless;
  logic                 running;
  logic [LVL_W-1:0]     res_level;
  logic                 res_alive;

  logic                 accept;
  logic                 r_run;
  logic                 r_endl;
  logic                 r_ad;
  logic                 r_sd;
  logic [AGE_W-1:0]     r_age;
  logic [TIME_BITS-1:0] a_eff;
  logic [TIME_BITS-1:0] s_eff;
  logic [TIME_BITS-1:0] a_n;
  logic [TIME_BITS-1:0] s_n;
  logic [SUM_W-1:0]     sum;
  logic [SUM_W-1:0]     nxt;
  logic [AGE_W-1:0]     age_next;
  logic                 ad_next;
  logic                 sd_next;
  logic                 run_next;
  logic                 need_div;
  logic [LVL_W-1:0]     lvl_const;
  logic [TIME_BITS-1:0] div_num;
  logic [TIME_BITS-1:0] div_den;

  div_ctrl_t            div_ctrl;
  div_stat_t            div_stat;
  logic [LVL_W-1:0]     quot;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      attack_time    <= '0;
      sustain_time   <= '0;
      decay_time     <= '0;
      looped_sustain <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[3:2])
        REG_ATTACK:  attack_time    <= pwdata[TIME_BITS-1:0];
        REG_SUSTAIN: sustain_time   <= pwdata[TIME_BITS-1:0];
        REG_DECAY:   decay_time     <= pwdata[TIME_BITS-1:0];
        REG_LOOPED:  looped_sustain <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ATTACK:  prdata = 32'(attack_time);
      REG_SUSTAIN: prdata = 32'(sustain_time);
      REG_DECAY:   prdata = 32'(decay_time);
      REG_LOOPED:  prdata = 32'(looped_sustain);
      default:     prdata = '0;
    endcase
  end

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    r_run  = s_tuser ? 1'b1 : running;
    r_endl = s_tuser ? (attack_time == '0 && sustain_time == '0 && decay_time == '0)
                     : endless;
    r_ad   = s_tuser ? 1'b0 : attack_done;
    r_sd   = s_tuser ? 1'b0 : sustain_done;
    r_age  = s_tuser ? '0 : phase_age;
    a_eff  = r_ad ? '0 : attack_time;
    s_eff  = r_sd ? '0 : sustain_time;
    sum    = SUM_W'(r_age) + SUM_W'(s_tdata);
    nxt    = (sum > AGE_MAX) ? AGE_MAX : sum;

    a_n       = a_eff;
    s_n       = s_eff;
    age_next  = r_age;
    ad_next   = r_ad;
    sd_next   = r_sd;
    run_next  = r_run;
    need_div  = 1'b0;
    lvl_const = '0;
    div_num   = '0;
    div_den   = '0;

    if (r_run && !r_endl) begin
      if (a_eff != '0 && nxt > SUM_W'(a_eff)) begin
        age_next = AGE_W'(nxt - SUM_W'(a_eff));
        ad_next  = 1'b1;
        a_n      = '0;
      end else if (a_eff == '0 && s_eff != '0) begin
        if (!looped_sustain) begin
          if (nxt > SUM_W'(s_eff)) begin
            age_next = '0;
            sd_next  = 1'b1;
            s_n      = '0;
          end else begin
            age_next = AGE_W'(nxt);
          end
        end
      end else begin
        age_next = AGE_W'(nxt);
      end

      if (a_n != '0) begin
        need_div = 1'b1;
        div_num  = (age_next > AGE_W'(a_n)) ? a_n : age_next[TIME_BITS-1:0];
        div_den  = a_n;
      end else if (s_n != '0) begin
        lvl_const = LEVEL_ONE;
      end else if (decay_time == '0 || age_next > AGE_W'(decay_time)) begin
        run_next = 1'b0;
      end else begin
        need_div = 1'b1;
        div_num  = decay_time - age_next[TIME_BITS-1:0];
        div_den  = decay_time;
      end
    end else if (r_run) begin
      lvl_const = LEVEL_ONE;
    end
  end

  assign div_ctrl.start = accept && need_div;

  asde_div #(
    .NUM_W (TIME_BITS),
    .Q_W   (LVL_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctrl (div_ctrl),
    .num  (div_num),
    .den  (div_den),
    .stat (div_stat),
    .quot (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      phase_age    <= '0;
      attack_done  <= 1'b0;
      sustain_done <= 1'b0;
      endless      <= 1'b1;
      running      <= 1'b1;
      m_tvalid     <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            phase_age    <= age_next;
            attack_done  <= ad_next;
            sustain_done <= sd_next;
            endless      <= r_endl;
            running      <= run_next;
            res_alive    <= run_next;
            res_level    <= lvl_const;
            state        <= need_div ? S_DIV : S_OUT;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            res_level <= quot;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= OUT_W'(res_level);
            m_tuser  <= res_alive;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_busy_blocks_input: assert property (@(posedge clk) disable iff (rst)
    div_stat.busy |-> !s_tready)
    else $error("input taken while divider busy");

  a_done_in_div: assert property (@(posedge clk) disable iff (rst)
    div_stat.done |-> state == S_DIV)
    else $error("divider finished outside divide state");

  a_endless_runs: assert property (@(posedge clk) disable iff (rst)
    endless |-> running)
    else $error("endless envelope not running");

  a_dead_is_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("finished envelope with nonzero strength");

endmodule

// File: tb/attack_sustain_decay_envelope_test.sv
`timescale 1ns / 1ps

module attack_sustain_decay_envelope_test;
  import asde_pkg::*;

  localparam int TIME_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int AGE_W = TIME_BITS + 1;
  localparam int LEVEL_W = FRAC_BITS + 1;
  localparam int TDATA_W = ((LEVEL_W + 7) / 8) * 8;
  localparam logic [63:0] AGE_MAX = (64'd1 << AGE_W) - 64'd1;
  localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(1) << FRAC_BITS;
  localparam int RANDOM_TICKS = 620;

  typedef struct packed {
    logic [LEVEL_W-1:0] strength;
    logic               alive;
  } envelope_out_t;

  typedef enum logic {ROW_TICK, ROW_WRITE} row_kind_t;

  typedef struct packed {
    row_kind_t          kind;
    logic [1:0]         reg_idx;
    logic [31:0]        reg_value;
    logic [15:0]        delta;
    logic               restart;
    logic               fixed;
    logic [LEVEL_W-1:0] fixed_strength;
    logic               fixed_alive;
  } stimulus_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [15:0] s_tdata;   // delta_time
  logic s_tuser;          // restart
  logic m_tvalid;
  logic m_tready;
  logic [TDATA_W-1:0] m_tdata;   // strength, zero fill
  logic m_tuser;                 // alive
  logic psel;
  logic penable;
  logic pwrite;
  logic [REG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  logic [TIME_BITS-1:0] cfg_attack;
  logic [TIME_BITS-1:0] cfg_sustain;
  logic [TIME_BITS-1:0] cfg_decay;
  logic                 cfg_looped;
  logic [AGE_W-1:0]     env_age;
  logic                 env_attack_done;
  logic                 env_sustain_done;
  logic                 env_endless;
  logic [LEVEL_W-1:0]   env_level;
  logic                 env_running;

  envelope_out_t strength_q[$];
  stimulus_row_t directed_rows[$];
  envelope_out_t front;
  int unsigned mismatches = 0;
  int unsigned stall_left;
  bit sender_bursts = 1'b0;
  bit receiver_steady = 1'b0;

  attack_sustain_decay_envelope #(
    .TIME_BITS(TIME_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  always #10 clk = ~clk;

  function automatic void restart_envelope();
    env_age = '0;
    env_attack_done = 1'b0;
    env_sustain_done = 1'b0;
    env_endless = (cfg_attack == 0) && (cfg_sustain == 0) && (cfg_decay == 0);
    env_level = LEVEL_ONE;
    env_running = 1'b1;
  endfunction

  function automatic void advance_envelope(input logic [15:0] delta, input logic restart,
                                           output envelope_out_t res);
    logic [63:0] a, s, d, nxt, age;
    if (restart) restart_envelope();
    if (env_running && !env_endless) begin
      a = env_attack_done ? 64'd0 : 64'(cfg_attack);
      s = env_sustain_done ? 64'd0 : 64'(cfg_sustain);
      d = 64'(cfg_decay);
      nxt = 64'(env_age) + 64'(delta);
      if (nxt > AGE_MAX) nxt = AGE_MAX;
      if (a != 0 && nxt > a) begin
        env_age = AGE_W'(nxt - a);
        env_attack_done = 1'b1;
        a = 0;
      end else if (a == 0 && s != 0) begin
        if (!cfg_looped) begin
          if (nxt > s) begin
            env_age = '0;
            env_sustain_done = 1'b1;
            s = 0;
          end else begin
            env_age = AGE_W'(nxt);
          end
        end
      end else begin
        env_age = AGE_W'(nxt);
      end
      if (a != 0) begin
        age = (64'(env_age) > a) ? a : 64'(env_age);
        env_level = LEVEL_W'((age << FRAC_BITS) / a);
      end else if (s != 0) begin
        env_level = LEVEL_ONE;
      end else if (d == 0 || 64'(env_age) > d) begin
        env_level = '0;
        env_running = 1'b0;
      end else begin
        env_level = LEVEL_W'(((d - 64'(env_age)) << FRAC_BITS) / d);
      end
    end else if (env_running) begin
      env_level = LEVEL_ONE;
    end else begin
      env_level = '0;
    end
    res.strength = env_level;
    res.alive = env_running;
  endfunction

  function automatic logic [TIME_BITS-1:0] pick_time(input int unsigned scale);
    case (scale)
      0: begin
        case ($urandom_range(0, 2))
          0: return '0;
          1: return TIME_MAX;
          default: return TIME_BITS'($urandom);
        endcase
      end
      1: return ($urandom_range(0, 4) == 0) ? '0 : TIME_BITS'($urandom_range(1, 400));
      default: return ($urandom_range(0, 4) == 0) ? '0 : TIME_BITS'($urandom_range(1, 20000));
    endcase
  endfunction

  task automatic add_row(input row_kind_t kind, input logic [1:0] reg_idx,
                         input logic [31:0] reg_value, input logic [15:0] delta,
                         input logic restart, input logic fixed,
                         input logic [LEVEL_W-1:0] fixed_strength, input logic fixed_alive);
    directed_rows.push_back('{kind, reg_idx, reg_value, delta, restart, fixed,
                              fixed_strength, fixed_alive});
  endtask

  task automatic send_tick(input logic [15:0] delta, input logic restart, input logic fixed,
                           input logic [LEVEL_W-1:0] fixed_strength, input logic fixed_alive);
    int unsigned gap;
    envelope_out_t want;
    gap = sender_bursts ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= delta;
    s_tuser <= restart;
    do @(posedge clk); while (!s_tready);
    advance_envelope(delta, restart, want);
    if (fixed) want = '{fixed_strength, fixed_alive};
    strength_q.push_back(want);
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (strength_q.size() != 0) @(posedge clk);
  endtask

  task automatic program_register(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= REG_ADDR_W'({idx, 2'b00});
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_ATTACK:  cfg_attack = value[TIME_BITS-1:0];
      REG_SUSTAIN: cfg_sustain = value[TIME_BITS-1:0];
      REG_DECAY:   cfg_decay = value[TIME_BITS-1:0];
      REG_LOOPED:  cfg_looped = value[0];
      default: ;
    endcase
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== value) begin
      mismatches++;
      $display("%0t: register %0d read expected %0h actual %0h", $time, idx, value, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // hold off the output at random, per item
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      stall_left <= 0;
    end else if (m_tvalid && m_tready) begin
      if (!receiver_steady && $urandom_range(0, 1) == 1) begin
        m_tready <= 1'b0;
        stall_left <= $urandom_range(1, 13);
      end
    end else if (!m_tready) begin
      if (stall_left <= 1) m_tready <= 1'b1;
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (strength_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected item strength %0d alive %0b", $time, m_tdata, m_tuser);
      end else begin
        front = strength_q.pop_front();
        if (m_tdata !== TDATA_W'(front.strength)) begin
          mismatches++;
          $display("%0t: strength expected %0d actual %0d", $time, front.strength, m_tdata);
        end
        if (m_tuser !== front.alive) begin
          mismatches++;
          $display("%0t: alive expected %0b actual %0b", $time, front.alive, m_tuser);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin : stimulus
    stimulus_row_t row;
    int unsigned random_ticks;
    int unsigned scale;
    int unsigned count;
    int unsigned lim;
    logic [15:0] delta;
    logic restart;
    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= 1'b0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    cfg_attack = '0;
    cfg_sustain = '0;
    cfg_decay = '0;
    cfg_looped = 1'b0;
    restart_envelope();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'hFFFF, 1'b0, 1'b1, LEVEL_ONE, 1'b1);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd0,    1'b1, 1'b1, LEVEL_ONE, 1'b1);
    add_row(ROW_WRITE, REG_ATTACK,  32'd100,      16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd10,   1'b0, 1'b1, LEVEL_ONE, 1'b1);
    add_row(ROW_WRITE, REG_SUSTAIN, 32'd50,       16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_DECAY,   32'd200,      16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd0,    1'b1, 1'b1, '0,        1'b1);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd50,   1'b0, 1'b1, 17'd32768, 1'b1);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd60,   1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd45,   1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd100,  1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd100,  1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd1,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'hFFFF, 1'b0, 1'b1, '0,        1'b0);
    add_row(ROW_WRITE, REG_LOOPED,  32'd1,        16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd0,    1'b1, 1'b1, '0,        1'b1);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd200,  1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'hFFFF, 1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_LOOPED,  32'd0,        16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd30,   1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_DECAY,   32'd0,        16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd5,    1'b0, 1'b1, '0,        1'b0);
    add_row(ROW_WRITE, REG_ATTACK,  32'hFFFFFF,   16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_SUSTAIN, 32'd0,        16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_DECAY,   32'hFFFFFF,   16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'hFFFF, 1'b1, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'hFFFF, 1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_ATTACK,  32'd0,        16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_SUSTAIN, 32'hFFFFFF,   16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'hFFFF, 1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_SUSTAIN, 32'd0,        16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_WRITE, REG_DECAY,   32'd0,        16'd0,    1'b0, 1'b0, '0,        1'b0);
    add_row(ROW_TICK,  REG_ATTACK,  32'd0,        16'd1,    1'b1, 1'b1, LEVEL_ONE, 1'b1);

    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      if (row.kind == ROW_WRITE) begin
        drain_results();
        program_register(row.reg_idx, row.reg_value);
      end else begin
        send_tick(row.delta, row.restart, row.fixed, row.fixed_strength, row.fixed_alive);
      end
    end

    random_ticks = 0;
    while (random_ticks < RANDOM_TICKS) begin
      drain_results();
      sender_bursts = ($urandom_range(0, 4) == 0);
      receiver_steady = ($urandom_range(0, 4) == 0);
      scale = $urandom_range(0, 9);
      scale = (scale == 0) ? 0 : (scale <= 6) ? 1 : 2;
      if ($urandom_range(0, 3) != 0) program_register(REG_ATTACK, 32'(pick_time(scale)));
      if ($urandom_range(0, 3) != 0) program_register(REG_SUSTAIN, 32'(pick_time(scale)));
      if ($urandom_range(0, 3) != 0) program_register(REG_DECAY, 32'(pick_time(scale)));
      if ($urandom_range(0, 3) != 0) program_register(REG_LOOPED, 32'($urandom_range(0, 3) == 0));
      lim = (32'(cfg_attack) + 32'(cfg_sustain) + 32'(cfg_decay)) / 8 + 1;
      if (lim > 65535) lim = 65535;
      count = $urandom_range(15, 50);
      for (int k = 0; k < count; k++) begin
        restart = (k == 0) ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 9))
          0: delta = '0;
          1: delta = 16'hFFFF;
          2: delta = 16'($urandom);
          default: delta = 16'($urandom_range(0, lim));
        endcase
        send_tick(delta, restart, 1'b0, '0, 1'b0);
        random_ticks++;
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
